### src/strongly_connected_components_macros.svh
// Assertion macros for the strongly connected components block.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH

// clocked check, off while reset is asserted
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/scc_pkg.sv
// Package for the strongly connected components block: sizes, codes, state type.
// No dependencies.
`default_nettype none
package scc_pkg;
  localparam int unsigned MAX_NODES_DEF = 32;
  localparam int unsigned MAX_EDGES_DEF = 1024;
  localparam int unsigned CW = 6;
  localparam int unsigned FW = 5;
  localparam logic [CW-1:0] NODE_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD, ST_ROOT, ST_ROOT_CHK, ST_LOAD, ST_WALK, ST_EDGE, ST_VCHK,
    ST_FIN, ST_POP, ST_POP_W, ST_RET, ST_RESTORE, ST_EMIT, ST_EMIT_W
  } state_t;
endpackage
`default_nettype wire

### src/scc_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module scc_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/scc_vram.sv
// Synchronous RAM with per-entry valid bits; unwritten entries read as RESET_VAL.
// Depends on nothing; clr drops all valid bits at once.
`default_nettype none
module scc_vram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_r;
  logic             rv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rv_r <= vld_r[raddr];
    end
  end

  assign rdata = rv_r ? rd_r : RESET_VAL;
endmodule
`default_nettype wire

### src/scc_engine.sv
// Edge loader, Tarjan search sequencer and result emitter.
// Depends on scc_pkg, scc_ram, scc_vram and the assertion macros.
`default_nettype none
`include "strongly_connected_components_macros.svh"
module scc_engine import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [CW-1:0] node_count,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_operation,
  input  wire logic [FW-1:0] in_from_node,
  input  wire logic [FW-1:0] in_to_node,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [FW-1:0]      out_node_index,
  output logic [CW-1:0]      out_component,
  output logic               out_last
);
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned SW  = NW + 1;
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned XW  = NW + EW;
  localparam int unsigned FRW = NW + EW + CW + CW;
  localparam logic [EW-1:0] NULL_E = EW'(MAX_EDGES);

  state_t state_r, state_nxt;
  logic [EW-1:0] etot_r, etot_nxt, cur_r, cur_nxt;
  logic [CW-1:0] root_r, root_nxt, idx_r, idx_nxt, vc_r, vc_nxt, cc_r, cc_nxt;
  logic [CW-1:0] low_r, low_nxt, visu_r, visu_nxt;
  logic [SW-1:0] sp_r, sp_nxt, fp_r, fp_nxt;
  logic [NW-1:0] u_r, u_nxt, v_r, v_nxt, from_r, from_nxt, to_r, to_nxt;
  logic [MAX_NODES-1:0] os_r, os_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [FW-1:0] out_idx_r, out_idx_nxt;
  logic [CW-1:0] out_comp_r, out_comp_nxt;

  logic [CW-1:0] n_eff;
  logic add_ok, accept;
  logic [NW-1:0] w_node, e_tgt, p_u;
  logic [EW-1:0] e_next, p_cur;
  logic [CW-1:0] p_low, p_vis;

  logic head_clr, head_we, vis_clr, vis_we, comp_clr, comp_we, edge_we, ns_we, fr_we;
  logic [NW-1:0] head_wa, head_ra, vis_wa, vis_ra, comp_wa, comp_ra, ns_wa, ns_ra, fr_wa, fr_ra;
  logic [EW-1:0] head_wd, head_rd;
  logic [CW-1:0] vis_wd, vis_rd, comp_wd, comp_rd;
  logic [EAW-1:0] edge_wa, edge_ra;
  logic [XW-1:0] edge_wd, edge_rd;
  logic [NW-1:0] ns_wd, ns_rd;
  logic [FRW-1:0] fr_wd, fr_rd;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign accept = in_valid && !in_stall;
  assign add_ok = ({1'b0, in_from_node} < n_eff) && ({1'b0, in_to_node} < n_eff)
                  && (etot_r != NULL_E);
  assign e_tgt  = edge_rd[XW-1:EW];
  assign e_next = edge_rd[EW-1:0];
  assign w_node = ns_rd;
  assign {p_u, p_cur, p_low, p_vis} = fr_rd;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_node_index = out_idx_r;
  assign out_component  = out_comp_r;
  assign out_last       = out_last_r;

  scc_vram #(.DEPTH(MAX_NODES), .WIDTH(EW), .RESET_VAL(NULL_E)) u_head (
    .clk, .rst_n, .clr(head_clr), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd));
  scc_vram #(.DEPTH(MAX_NODES), .WIDTH(CW), .RESET_VAL('0)) u_vis (
    .clk, .rst_n, .clr(vis_clr), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
    .raddr(vis_ra), .rdata(vis_rd));
  scc_vram #(.DEPTH(MAX_NODES), .WIDTH(CW), .RESET_VAL('0)) u_comp (
    .clk, .rst_n, .clr(comp_clr), .we(comp_we), .waddr(comp_wa), .wdata(comp_wd),
    .raddr(comp_ra), .rdata(comp_rd));
  scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(XW)) u_edge (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_nstack (
    .clk, .we(ns_we), .waddr(ns_wa), .wdata(ns_wd), .raddr(ns_ra), .rdata(ns_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FRW)) u_frame (
    .clk, .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ADD && add_ok) begin
            state_nxt = ST_ADD;
          end else if (in_operation == OP_COMPUTE) begin
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ADD:      state_nxt = ST_IDLE;
      ST_ROOT:     state_nxt = (root_r == n_eff) ? ST_EMIT : ST_ROOT_CHK;
      ST_ROOT_CHK: state_nxt = (vis_rd != '0) ? ST_ROOT : ST_LOAD;
      ST_LOAD:     state_nxt = ST_WALK;
      ST_WALK:     state_nxt = (cur_r != NULL_E) ? ST_EDGE : ST_FIN;
      ST_EDGE:     state_nxt = (32'(e_tgt) < 32'(n_eff)) ? ST_VCHK : ST_WALK;
      ST_VCHK:     state_nxt = (vis_rd == '0) ? ST_LOAD : ST_WALK;
      ST_FIN:      state_nxt = (low_r == visu_r) ? ST_POP : ST_RET;
      ST_POP:      state_nxt = (sp_r == '0) ? ST_RET : ST_POP_W;
      ST_POP_W:    state_nxt = (w_node == u_r) ? ST_RET : ST_POP;
      ST_RET:      state_nxt = (fp_r == '0) ? ST_ROOT : ST_RESTORE;
      ST_RESTORE:  state_nxt = ST_WALK;
      ST_EMIT:     state_nxt = out_valid_r ? ST_EMIT : ST_EMIT_W;
      ST_EMIT_W:   state_nxt = (idx_r + CW'(1) == n_eff) ? ST_IDLE : ST_EMIT;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    etot_nxt = etot_r;  cur_nxt = cur_r;   root_nxt = root_r; idx_nxt = idx_r;
    vc_nxt = vc_r;      cc_nxt = cc_r;     low_nxt = low_r;   visu_nxt = visu_r;
    sp_nxt = sp_r;      fp_nxt = fp_r;     u_nxt = u_r;       v_nxt = v_r;
    from_nxt = from_r;  to_nxt = to_r;     os_nxt = os_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt = out_idx_r; out_comp_nxt = out_comp_r; out_last_nxt = out_last_r;
    head_clr = 1'b0; head_we = 1'b0; head_wa = from_r; head_wd = etot_r; head_ra = '0;
    vis_clr = 1'b0;  vis_we = 1'b0;  vis_wa = '0; vis_wd = '0; vis_ra = '0;
    comp_clr = 1'b0; comp_we = 1'b0; comp_wa = '0; comp_wd = cc_r; comp_ra = '0;
    edge_we = 1'b0;  edge_wa = etot_r[EAW-1:0]; edge_wd = {to_r, head_rd}; edge_ra = '0;
    ns_we = 1'b0;    ns_wa = sp_r[NW-1:0]; ns_wd = '0; ns_ra = '0;
    fr_we = 1'b0;    fr_wa = fp_r[NW-1:0]; fr_wd = {u_r, cur_r, low_r, visu_r}; fr_ra = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_ADD: begin
              from_nxt = NW'(in_from_node);
              to_nxt   = NW'(in_to_node);
              head_ra  = NW'(in_from_node);
            end
            OP_CLEAR: begin
              head_clr = 1'b1;
              etot_nxt = '0;
            end
            OP_COMPUTE: begin
              vis_clr = 1'b1; comp_clr = 1'b1; os_nxt = '0;
              vc_nxt = '0; cc_nxt = '0; root_nxt = '0; sp_nxt = '0; fp_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        edge_we  = 1'b1;
        head_we  = 1'b1;
        etot_nxt = etot_r + EW'(1);
      end
      ST_ROOT: begin
        vis_ra  = NW'(root_r);
        idx_nxt = '0;
      end
      ST_ROOT_CHK: begin
        if (vis_rd != '0) begin
          root_nxt = root_r + CW'(1);
        end else begin
          vc_nxt = vc_r + CW'(1);
          vis_we = 1'b1; vis_wa = NW'(root_r); vis_wd = vc_r + CW'(1);
          ns_we = 1'b1; ns_wd = NW'(root_r); sp_nxt = sp_r + SW'(1);
          os_nxt[NW'(root_r)] = 1'b1;
          u_nxt = NW'(root_r); low_nxt = vc_r + CW'(1); visu_nxt = vc_r + CW'(1);
          head_ra = NW'(root_r); fp_nxt = '0;
        end
      end
      ST_LOAD: cur_nxt = head_rd;
      ST_WALK: edge_ra = cur_r[EAW-1:0];
      ST_EDGE: begin
        v_nxt = e_tgt; cur_nxt = e_next; vis_ra = e_tgt;
      end
      ST_VCHK: begin
        if (vis_rd == '0) begin
          vc_nxt = vc_r + CW'(1);
          vis_we = 1'b1; vis_wa = v_r; vis_wd = vc_r + CW'(1);
          ns_we = 1'b1; ns_wd = v_r; sp_nxt = sp_r + SW'(1);
          os_nxt[v_r] = 1'b1;
          fr_we = 1'b1; fp_nxt = fp_r + SW'(1);
          u_nxt = v_r; low_nxt = vc_r + CW'(1); visu_nxt = vc_r + CW'(1);
          head_ra = v_r;
        end else if (os_r[v_r] && low_r > vis_rd) begin
          low_nxt = vis_rd;
        end
      end
      ST_FIN: begin
        if (low_r == visu_r) begin
          cc_nxt = cc_r + CW'(1);
        end
      end
      ST_POP: begin
        if (sp_r != '0) begin
          ns_ra = NW'(sp_r - SW'(1));
          sp_nxt = sp_r - SW'(1);
        end
      end
      ST_POP_W: begin
        os_nxt[w_node] = 1'b0;
        comp_we = 1'b1; comp_wa = w_node;
      end
      ST_RET: begin
        if (fp_r == '0) begin
          root_nxt = root_r + CW'(1);
        end else begin
          fr_ra = NW'(fp_r - SW'(1));
          fp_nxt = fp_r - SW'(1);
        end
      end
      ST_RESTORE: begin
        u_nxt = p_u; cur_nxt = p_cur; visu_nxt = p_vis;
        low_nxt = (p_low > low_r) ? low_r : p_low;
      end
      ST_EMIT: begin
        comp_ra = NW'(idx_r);
      end
      ST_EMIT_W: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = FW'(idx_r);
        out_comp_nxt  = comp_rd;
        out_last_nxt  = (idx_r + CW'(1) == n_eff);
        idx_nxt       = idx_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      etot_r <= '0; root_r <= '0; idx_r <= '0; vc_r <= '0; cc_r <= '0;
      sp_r <= '0; fp_r <= '0; os_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      etot_r <= etot_nxt; root_r <= root_nxt; idx_r <= idx_nxt; vc_r <= vc_nxt;
      cc_r <= cc_nxt; sp_r <= sp_nxt; fp_r <= fp_nxt; os_r <= os_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; low_r <= low_nxt; visu_r <= visu_nxt; u_r <= u_nxt; v_r <= v_nxt;
    from_r <= from_nxt; to_r <= to_nxt;
    out_idx_r <= out_idx_nxt; out_comp_r <= out_comp_nxt; out_last_r <= out_last_nxt;
  end

  `SCC_ASSERT(a_emit_slot_free, (state_r == ST_EMIT_W) |-> !out_valid_r, "result overwrite")
  `SCC_ASSERT(a_frames_le_stack, (state_r == ST_WALK) |-> (fp_r < sp_r), "frame depth")
  `SCC_ASSERT(a_sp_bound, 32'(sp_r) <= MAX_NODES, "node stack overflow")
  `SCC_ASSERT(a_edge_bound, 32'(etot_r) <= MAX_EDGES, "edge count overflow")
endmodule
`default_nettype wire

### src/strongly_connected_components.sv
// Top level: node count register on the APB-style port and the search engine.
// Depends on scc_pkg and scc_engine.
//
//  channel | ports                                 | item accepted when
//  in      | in_operation, in_from_node, in_to_node| in_valid && !in_stall
//  out     | out_node_index, out_component, out_last| out_valid && !out_stall
//  cfg     | cfg_psel/penable/pwrite/paddr/pwdata  | psel && penable && pwrite
//
// Add edge: head read, then edge and head write; dropped if out of range or full.
// Compute: tries each root in turn, walks each edge of a node and opens unvisited
// targets, returns nodes, pops the stack; then emits the results, held by out_stall.
// Reset is synchronous, node count returns to 32 and the edge store empties at once.
// in_stall is high while an item is at work; out_stall holds results and the emitter.
`default_nettype none
module strongly_connected_components import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_operation,
  input  wire logic [FW-1:0] in_from_node,
  input  wire logic [FW-1:0] in_to_node,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [FW-1:0]      out_node_index,
  output logic [CW-1:0]      out_component,
  output logic               out_last
);
  logic [CW-1:0] node_count_r, node_count_nxt;
  logic          sel_nc;

  assign cfg_pready = 1'b1;
  assign sel_nc     = (cfg_paddr[2] == REG_NODE_COUNT);
  assign cfg_prdata = sel_nc ? {26'd0, node_count_r} : 32'd0;

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_nc) begin
      node_count_nxt = cfg_pwdata[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  scc_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
    .clk, .rst_n, .node_count(node_count_r),
    .in_valid, .in_stall, .in_operation, .in_from_node, .in_to_node,
    .out_valid, .out_stall, .out_node_index, .out_component, .out_last);
endmodule
`default_nettype wire
